@@ rtl/slpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_pkg: shared constants and types for the single-linkage clustering block
// Sizes of the point and distance stores and the request that passes from the
// front end to the clustering engine.
// ----------------------------------------------------------------------------
package slpc_pkg;
  localparam int MAX_POINTS     = 256;
  localparam int COORD_BITS     = 16;
  localparam int IN_COORD_W     = 16;
  localparam int IDX_W          = $clog2(MAX_POINTS);
  localparam int CNT_W          = $clog2(MAX_POINTS + 1);
  localparam int DIST_W         = 2 * COORD_BITS + 2;
  localparam int TRI_DEPTH      = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int TRI_W          = $clog2(TRI_DEPTH);
  localparam int TRI_CW         = $clog2(TRI_DEPTH + 1);
  localparam int MC_W           = 7;
  localparam int MAX_MERGES     = 64;
  localparam int DEFAULT_MERGES = 10;
  localparam int OUT_IDX_W      = 8;
  localparam int OUT_DIST_W     = 34;
  localparam int OUT_SIZE_W     = 9;

  // One classified point request from the front end.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [CNT_W-1:0]      slot;
    logic                  drop;
    logic                  last;
    logic                  ovf;
  } pt_req_t;
endpackage
`default_nettype wire

@@ rtl/slpc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_in_if: point input channel
// Valid/ready channel carrying one 3-D point and its end-of-set mark.
// ----------------------------------------------------------------------------
interface slpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [15:0] coord_z;
  logic        last_point;
  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface
`default_nettype wire

@@ rtl/slpc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_out_if: merge result channel
// Valid/ready channel carrying one merge result.
// ----------------------------------------------------------------------------
interface slpc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  survivor_index;
  logic [7:0]  absorbed_index;
  logic [33:0] link_distance;
  logic [8:0]  merged_size;
  logic        no_pair_error;
  logic        points_dropped;
  logic        last_result;
  modport source (output valid, survivor_index, absorbed_index, link_distance,
                  merged_size, no_pair_error, points_dropped, last_result,
                  input ready);
  modport sink   (input valid, survivor_index, absorbed_index, link_distance,
                  merged_size, no_pair_error, points_dropped, last_result,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/single_linkage_point_clustering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one point per cycle while the engine is idle; a two-entry
//   request queue lets the intake run two points ahead of it.
// A run first builds the distance triangle over all point pairs, then for each
//   merge scans the triangle for the closest pair, updates the merged row and
//   the cluster size, and emits the result.
// Reset: synchronous, active low; clears counters and valid and sets the merge count to 10.
// ----------------------------------------------------------------------------
// single_linkage_point_clustering: single-linkage clustering of 3-D points
// Loads a set of points and emits one result per closest-pair merge, or a no-pair error.
// ----------------------------------------------------------------------------
module single_linkage_point_clustering (
  input  wire       clk,
  input  wire       rst_n,
  slpc_in_if.sink   in_ch,
  slpc_out_if.source out_ch,
  input  wire       cfg_we,
  input  wire [6:0] cfg_wdata
);
  import slpc_pkg::*;

  // Front end to engine request path.
  logic    q_push, q_full, q_pop, q_valid;
  pt_req_t q_wdata, q_rdata;

  // The front end numbers each point, marks those beyond the store's
  // capacity and tracks whether any were dropped in the current set.
  slpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  slpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  // The engine only takes a request while idle, so the point store is never
  // overwritten under a running clustering pass.
  slpc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  // The queue is never pushed while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("request queue overflow");

  // An error result always ends the run and carries zero fields.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_pair_error) |->
      (out_ch.last_result && out_ch.link_distance == '0 && out_ch.merged_size == '0))
    else $error("malformed no-pair result");

  // A merge always keeps the higher index.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.no_pair_error) |->
      (out_ch.survivor_index > out_ch.absorbed_index && out_ch.merged_size >= 9'd2))
    else $error("merge result out of order");
endmodule
`default_nettype wire

@@ rtl/slpc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_front: point intake
// Accepts points, assigns store slots and flags points beyond capacity.
// ----------------------------------------------------------------------------
module slpc_front (
  input  wire                  clk,
  input  wire                  rst_n,
  slpc_in_if.sink              in_ch,
  input  wire                  q_full,
  output logic                 q_push,
  output slpc_pkg::pt_req_t    q_wdata
);
  import slpc_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             full_store;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign full_store  = (cnt_r == CNT_W'(MAX_POINTS));

  always_comb begin
    q_wdata.x    = COORD_BITS'(in_ch.coord_x);
    q_wdata.y    = COORD_BITS'(in_ch.coord_y);
    q_wdata.z    = COORD_BITS'(in_ch.coord_z);
    q_wdata.slot = cnt_r;
    q_wdata.drop = full_store;
    q_wdata.last = in_ch.last_point;
    q_wdata.ovf  = ovf_r || full_store;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (q_push) begin
      if (in_ch.last_point) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (full_store) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/slpc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_queue: two-entry request queue
// Decouples the intake from the clustering engine.
// ----------------------------------------------------------------------------
module slpc_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  slpc_pkg::pt_req_t    wdata,
  output logic                 full,
  input  wire                  pop,
  output logic                 not_empty,
  output slpc_pkg::pt_req_t    rdata
);
  import slpc_pkg::*;

  pt_req_t    mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/slpc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_engine: clustering engine
// Stores points, builds the distance triangle and runs the merges.
// ----------------------------------------------------------------------------
module slpc_engine (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [6:0]            cfg_wdata,
  input  wire                  q_valid,
  input  slpc_pkg::pt_req_t    q_rdata,
  output logic                 q_pop,
  slpc_out_if.source           out_ch
);
  import slpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_BROW, S_BRWT, S_BCOL, S_BCWT, S_BSUM,
    S_SCAN0, S_SCAN, S_MJ, S_MRA, S_MRB, S_MCMP, S_MWB,
    S_SZ, S_SZ2, S_SZ3, S_EMIT, S_ERR
  } state_t;

  localparam logic [DIST_W-1:0] ONES = '1;

  state_t state_r;

  logic [3*COORD_BITS-1:0] pt_mem [MAX_POINTS];
  logic [DIST_W-1:0]       dist_mem [TRI_DEPTH];
  logic [CNT_W-1:0]        size_mem [MAX_POINTS];

  logic [3*COORD_BITS-1:0] pt_q;
  logic [DIST_W-1:0]       dq;
  logic [CNT_W-1:0]        sz_q;

  logic [MC_W-1:0]         mc_r, merges_r, m_r;
  logic [CNT_W-1:0]        n_r, i_r, j_r, si_r, sj_r;
  logic [IDX_W-1:0]        a_r, b_r;
  logic [TRI_CW-1:0]       addr_r, tot_r;
  logic [TRI_W-1:0]        pa_r, pb_r;
  logic [DIST_W-1:0]       best_r, da_r;
  logic [CNT_W-1:0]        sa_r, msize_r;
  logic [3*COORD_BITS-1:0] pi_r;
  logic [2*COORD_BITS-1:0] sqx_r, sqy_r, sqz_r;
  logic                    rv_r, ovf_r;

  logic                    out_valid_r;
  logic [OUT_IDX_W-1:0]    o_surv_r, o_absb_r;
  logic [OUT_DIST_W-1:0]   o_dist_r;
  logic [OUT_SIZE_W-1:0]   o_size_r;
  logic                    o_err_r, o_drop_r, o_last_r;

  logic                    dist_we, pt_we, sz_we;
  logic [TRI_W-1:0]        dist_addr;
  logic [DIST_W-1:0]       dist_wd;
  logic [IDX_W-1:0]        pt_raddr, sz_addr;
  logic [CNT_W-1:0]        sz_wd;
  logic [DIST_W-1:0]       dsum;
  logic [COORD_BITS-1:0]   dx, dy, dz;
  logic [TRI_W-1:0]        pa_c, pb_c;
  logic                    slot_free, last_merge, emit_fire;
  logic [IDX_W-1:0]        j_idx;

  function automatic logic [COORD_BITS-1:0] adiff(input logic [COORD_BITS-1:0] p,
                                                  input logic [COORD_BITS-1:0] q);
    adiff = (p > q) ? p - q : q - p;
  endfunction

  function automatic logic [TRI_W-1:0] tri_idx(input logic [IDX_W-1:0] p,
                                               input logic [IDX_W-1:0] q);
    logic [IDX_W-1:0]   hi, lo;
    logic [2*IDX_W-1:0] prod;
    hi   = (p > q) ? p : q;
    lo   = (p > q) ? q : p;
    prod = (2*IDX_W)'(hi) * (2*IDX_W)'(hi - 1'b1);
    tri_idx = TRI_W'(prod >> 1) + TRI_W'(lo);
  endfunction

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign pt_we      = q_pop && !q_rdata.drop;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign emit_fire  = slot_free && ((state_r == S_EMIT) || (state_r == S_ERR));
  assign last_merge = (m_r + 1'b1 == merges_r);
  assign j_idx      = j_r[IDX_W-1:0];
  assign pa_c       = tri_idx(a_r, j_idx);
  assign pb_c       = tri_idx(b_r, j_idx);
  assign dsum       = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  assign dx = adiff(pi_r[3*COORD_BITS-1:2*COORD_BITS], pt_q[3*COORD_BITS-1:2*COORD_BITS]);
  assign dy = adiff(pi_r[2*COORD_BITS-1:COORD_BITS], pt_q[2*COORD_BITS-1:COORD_BITS]);
  assign dz = adiff(pi_r[COORD_BITS-1:0], pt_q[COORD_BITS-1:0]);

  always_comb begin
    dist_we   = 1'b0;
    dist_addr = addr_r[TRI_W-1:0];
    dist_wd   = dsum;
    pt_raddr  = i_r[IDX_W-1:0];
    sz_we     = 1'b0;
    sz_addr   = a_r;
    sz_wd     = msize_r;
    case (state_r)
      S_BROW: begin
        sz_we   = (i_r != n_r);
        sz_addr = i_r[IDX_W-1:0];
        sz_wd   = CNT_W'(1);
      end
      S_BCOL:  pt_raddr = j_idx;
      S_BSUM:  dist_we = 1'b1;
      S_MRA:   dist_addr = pa_r;
      S_MRB:   dist_addr = pb_r;
      S_MCMP: begin
        dist_addr = pa_r;
        dist_we   = (dq < da_r);
        dist_wd   = dq;
      end
      S_MWB: begin
        dist_addr = pb_r;
        dist_we   = 1'b1;
        dist_wd   = ONES;
      end
      S_SZ2:   sz_addr = b_r;
      S_SZ3: begin
        sz_we = 1'b1;
        sz_wd = sa_r + sz_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[q_rdata.slot[IDX_W-1:0]] <= {q_rdata.x, q_rdata.y, q_rdata.z};
    pt_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_addr] <= dist_wd;
    dq <= dist_mem[dist_addr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_addr] <= sz_wd;
    sz_q <= size_mem[sz_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mc_r        <= MC_W'(DEFAULT_MERGES);
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      if (cfg_we) mc_r <= cfg_wdata;
      if (emit_fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ovf_r <= q_rdata.ovf;
            if (q_rdata.last) begin
              n_r    <= q_rdata.slot + CNT_W'(!q_rdata.drop);
              i_r    <= '0;
              addr_r <= '0;
              m_r    <= '0;
              if (mc_r == '0) merges_r <= MC_W'(1);
              else if (mc_r > MC_W'(MAX_MERGES)) merges_r <= MC_W'(MAX_MERGES);
              else merges_r <= mc_r;
              state_r <= S_BROW;
            end
          end
        end
        S_BROW: begin
          if (i_r == n_r) begin
            tot_r   <= addr_r;
            state_r <= S_SCAN0;
          end else begin
            state_r <= S_BRWT;
          end
        end
        S_BRWT: begin
          pi_r    <= pt_q;
          j_r     <= '0;
          state_r <= S_BCOL;
        end
        S_BCOL: begin
          if (j_r == i_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_BROW;
          end else begin
            state_r <= S_BCWT;
          end
        end
        S_BCWT: begin
          sqx_r   <= dx * dx;
          sqy_r   <= dy * dy;
          sqz_r   <= dz * dz;
          state_r <= S_BSUM;
        end
        S_BSUM: begin
          addr_r  <= addr_r + 1'b1;
          j_r     <= j_r + 1'b1;
          state_r <= S_BCOL;
        end
        S_SCAN0: begin
          best_r  <= ONES;
          addr_r  <= '0;
          i_r     <= CNT_W'(1);
          j_r     <= '0;
          rv_r    <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          rv_r <= (addr_r != tot_r);
          si_r <= i_r;
          sj_r <= j_r;
          if (addr_r != tot_r) begin
            addr_r <= addr_r + 1'b1;
            if (j_r + 1'b1 == i_r) begin
              i_r <= i_r + 1'b1;
              j_r <= '0;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
          if (rv_r && (dq < best_r)) begin
            best_r <= dq;
            a_r    <= si_r[IDX_W-1:0];
            b_r    <= sj_r[IDX_W-1:0];
          end
          if ((addr_r == tot_r) && !rv_r) begin
            j_r     <= '0;
            state_r <= (best_r == ONES) ? S_ERR : S_MJ;
          end
        end
        S_MJ: begin
          pa_r <= pa_c;
          pb_r <= pb_c;
          if (j_r == n_r) state_r <= S_SZ;
          else if (j_idx == b_r) j_r <= j_r + 1'b1;
          else if (j_idx == a_r) state_r <= S_MWB;
          else state_r <= S_MRA;
        end
        S_MRA:  state_r <= S_MRB;
        S_MRB: begin
          da_r    <= dq;
          state_r <= S_MCMP;
        end
        S_MCMP: state_r <= S_MWB;
        S_MWB: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_MJ;
        end
        S_SZ:   state_r <= S_SZ2;
        S_SZ2: begin
          sa_r    <= sz_q;
          state_r <= S_SZ3;
        end
        S_SZ3: begin
          msize_r <= sa_r + sz_q;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            o_surv_r    <= OUT_IDX_W'(a_r);
            o_absb_r    <= OUT_IDX_W'(b_r);
            o_dist_r    <= OUT_DIST_W'(best_r);
            o_size_r    <= OUT_SIZE_W'(msize_r);
            o_err_r     <= 1'b0;
            o_drop_r    <= ovf_r;
            o_last_r    <= last_merge;
            m_r         <= m_r + 1'b1;
            state_r     <= last_merge ? S_IDLE : S_SCAN0;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            o_surv_r    <= '0;
            o_absb_r    <= '0;
            o_dist_r    <= '0;
            o_size_r    <= '0;
            o_err_r     <= 1'b1;
            o_drop_r    <= ovf_r;
            o_last_r    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.survivor_index = o_surv_r;
  assign out_ch.absorbed_index = o_absb_r;
  assign out_ch.link_distance  = o_dist_r;
  assign out_ch.merged_size    = o_size_r;
  assign out_ch.no_pair_error  = o_err_r;
  assign out_ch.points_dropped = o_drop_r;
  assign out_ch.last_result    = o_last_r;
endmodule
`default_nettype wire
